@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at each rising clock edge, held off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at each rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/enw_pkg.sv @@
package enw_pkg;

    // Sizing of the block.
    localparam int MAX_EDGES   = 64;
    localparam int NUM_TYPES   = 16;
    localparam int WEIGHT_BITS = 16;

    // Field widths fixed by the stream format.
    localparam int TYPE_W  = 4;
    localparam int SCALE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = ((WEIGHT_BITS + TYPE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WEIGHT_BITS + TYPE_W + 7) / 8) * 8;

    // Derived widths.
    localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int GRP_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int SUM_W  = WEIGHT_BITS + ADDR_W;
    localparam int NT_W   = $clog2(NUM_TYPES + 1);
    localparam int DIV_W  = SUM_W + NT_W;
    localparam int PROD_W = WEIGHT_BITS + SCALE_W;

    // 1.0 in Q8.8, used where the selected group or total sum is zero.
    localparam int ONE_Q88 = 256;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(1);
    localparam logic [SCALE_W-1:0]   SCALE_RESET = SCALE_W'(256);

    typedef logic [GRP_W-1:0] t_grp;

    // One buffered edge as held in the edge memory.
    typedef struct packed {
        logic [TYPE_W-1:0]      etype;
        logic [WEIGHT_BITS-1:0] weight;
    } t_edge_word;

    // Types beyond the last group fold into the last group.
    function automatic t_grp group_of(input logic [TYPE_W-1:0] t);
        t_grp g;
        if (int'(t) >= NUM_TYPES) begin
            g = t_grp'(NUM_TYPES - 1);
        end else begin
            g = t_grp'(t);
        end
        return g;
    endfunction

endpackage

@@ rtl/edge_weight_normalizer.sv @@
// Channel  | Direction | Word                                          | Accepted when
// s_axis   | in        | tdata: edge_weight, edge_type; tlast: last    | tvalid && tready
// m_axis   | out       | tdata: new_weight, out_type; tlast; tuser     | tvalid && tready
// cfg      | in        | index 0 scale, index 1 per_type_mode          | valid && ready
//
// Collection takes one edge word per cycle; tready is low from the last edge until the
// last result of that vertex has been handed to the output register.
// Each result passes through a memory read, an operand load with both multipliers,
// 32 steps of the radix-2 divider, the done report of the divider and a hand-off;
// a stalled output adds its wait.
// Reset is synchronous and active low; the edge memory holds no reset and needs no sweep.
// The output register lets the next vertex start collecting while its last result waits.
`include "assert_macros.svh"

module edge_weight_normalizer import enw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input edges.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [15:0] edge_weight, [19:16] edge_type
    input  logic                  i_s_axis_tlast,
    // Rescaled edges.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // [15:0] new_weight, [19:16] out_type
    output logic                  o_m_axis_tlast,
    output logic                  o_m_axis_tuser,  // [0] overflowed
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_READ,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_count;
    logic [ADDR_W-1:0]      r_idx;
    logic [SUM_W-1:0]       r_sums [NUM_TYPES];
    logic [SUM_W-1:0]       r_total;
    logic [NUM_TYPES-1:0]   r_present;
    logic [NT_W-1:0]        r_ntypes;
    logic                   r_drop;
    logic [SCALE_W-1:0]     r_scale;
    logic                   r_mode;
    logic [TYPE_W-1:0]      r_cur_type;
    logic                   r_cur_last;
    logic                   r_out_valid;
    logic [WEIGHT_BITS-1:0] r_out_weight;
    logic [TYPE_W-1:0]      r_out_type;
    logic                   r_out_last;
    logic                   r_out_ovf;

    logic                   in_fire;
    logic                   out_free;
    logic                   has_room;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic [TYPE_W-1:0]      in_type;
    t_edge_word             wr_word;
    t_edge_word             rd_word;
    t_grp                   sums_grp;
    logic [SUM_W-1:0]       sums_rd;
    logic [SUM_W-1:0]       sum_sel;
    logic [SUM_W-1:0]       sum_eff;
    logic [NT_W-1:0]        nt_eff;
    logic [PROD_W-1:0]      div_dividend;
    logic [DIV_W-1:0]       div_divisor;
    logic                   div_done;
    logic [WEIGHT_BITS-1:0] div_quot;
    logic                   cur_last;

    // Unpacking of the input word and the handshakes.
    assign in_weight       = i_s_axis_tdata[WEIGHT_BITS-1:0];
    assign in_type         = i_s_axis_tdata[WEIGHT_BITS +: TYPE_W];
    assign o_s_axis_tready = (r_state == S_COLLECT);
    assign in_fire         = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free        = !r_out_valid | i_m_axis_tready;
    assign has_room        = (r_count < CNT_W'(MAX_EDGES));
    assign o_cfg_ready     = 1'b1;

    assign wr_word.etype  = in_type;
    assign wr_word.weight = in_weight;

    // Edge memory, written while collecting and read in arrival order.
    enw_ram #(
        .WIDTH($bits(t_edge_word)),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire & has_room),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (wr_word),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_word)
    );

    // One read port on the group sums, shared by accumulation and emission.
    always_comb begin
        sums_grp = (r_state == S_COLLECT) ? group_of(in_type) : group_of(rd_word.etype);
        sums_rd  = r_sums[sums_grp];
        sum_sel  = r_mode ? sums_rd : r_total;
        sum_eff  = (sum_sel == '0) ? SUM_W'(ONE_Q88) : sum_sel;
        nt_eff   = (r_mode && (r_ntypes != '0)) ? r_ntypes : NT_W'(1);
        div_dividend = PROD_W'(rd_word.weight) * PROD_W'(r_scale);
        div_divisor  = DIV_W'(sum_eff) * DIV_W'(nt_eff);
        cur_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    end

    // The shared divider; operands are registered inside it at start.
    enw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer, vertex state, registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_idx       <= '0;
            r_total     <= '0;
            r_present   <= '0;
            r_ntypes    <= '0;
            r_drop      <= 1'b0;
            r_scale     <= SCALE_RESET;
            r_mode      <= 1'b1;
            r_out_valid <= 1'b0;
            for (int g = 0; g < NUM_TYPES; g++) begin
                r_sums[g] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_MODE:  r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // In the emit state the output register is reloaded instead.
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_COLLECT: begin
                    if (in_fire) begin
                        if (has_room) begin
                            r_sums[sums_grp] <= sums_rd + SUM_W'(in_weight);
                            r_total          <= r_total + SUM_W'(in_weight);
                            r_count          <= r_count + CNT_W'(1);
                            if (!r_present[sums_grp]) begin
                                r_present[sums_grp] <= 1'b1;
                                r_ntypes            <= r_ntypes + NT_W'(1);
                            end
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_idx   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cur_type <= rd_word.etype;
                    r_cur_last <= cur_last;
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_weight <= div_quot;
                        r_out_type   <= r_cur_type;
                        r_out_last   <= r_cur_last;
                        r_out_ovf    <= r_drop;
                        if (r_cur_last) begin
                            r_count   <= '0;
                            r_total   <= '0;
                            r_present <= '0;
                            r_ntypes  <= '0;
                            r_drop    <= 1'b0;
                            for (int g = 0; g < NUM_TYPES; g++) begin
                                r_sums[g] <= '0;
                            end
                            r_state <= S_COLLECT;
                        end else begin
                            r_idx   <= r_idx + ADDR_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    // Output word packing.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_type, r_out_weight});
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_ovf;

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_EDGES), "edge count too large")
    `ASSERT_CLK(a_ntypes_match, i_clk, i_rst_n, r_ntypes == NT_W'($countones(r_present)),
        "type count out of step with presence bits")
    `ASSERT_CLK(a_last_starts, i_clk, i_rst_n, in_fire && i_s_axis_tlast |=>
        r_state == S_READ && r_idx == '0, "emission did not start after the last edge")
    `ASSERT_CLK(a_list_clears, i_clk, i_rst_n,
        r_state == S_EMIT && out_free && r_cur_last |=> r_count == '0 && !r_drop,
        "vertex state not cleared after its last result")

endmodule

@@ rtl/enw_ram.sv @@
module enw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/enw_div.sv @@
`include "assert_macros.svh"

module enw_div import enw_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PROD_W-1:0]      i_dividend,
    input  logic [DIV_W-1:0]       i_divisor,
    output logic                   o_done,
    output logic [WEIGHT_BITS-1:0] o_quot
);

    localparam int STEP_W = (PROD_W > 1) ? $clog2(PROD_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [PROD_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;

    logic [DIV_W:0]    rem_sh;
    logic [DIV_W:0]    rem_sub;
    logic              take;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        rem_sh  = {r_rem, r_quo[PROD_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        take    = (rem_sh >= {1'b0, r_div});
    end

    // The quotient register doubles as the dividend shifter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(PROD_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[PROD_W-2:0], take};
                r_rem <= take ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    // Quotients above the weight range saturate.
    assign o_quot = (|r_quo[PROD_W-1:WEIGHT_BITS]) ? '1 : r_quo[WEIGHT_BITS-1:0];
    assign o_done = r_done;

    `ASSERT_CLK(a_no_restart, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")
    `ASSERT_CLK(a_start_busy, i_clk, i_rst_n, i_start |=> r_busy, "divider did not start")
    `ASSERT_CLK(a_done_after, i_clk, i_rst_n, r_done |-> !r_busy && $past(r_busy), "stray done")

endmodule
